@@ hw/rtl/sbei_pkg.sv @@
// shared types, constants and fixed-point helpers for the sphere body integrator
// no dependencies; used by sbei_lane, sbei_merge and the top level
`timescale 1ns / 1ps
`default_nettype none

package sbei_pkg;

    localparam int NUM_LANES = 3;
    localparam int FIX_W     = 32;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 66;

    // action codes carried in tuser
    localparam logic [2:0] ACT_FORCE   = 3'd0;
    localparam logic [2:0] ACT_TORQUE  = 3'd1;
    localparam logic [2:0] ACT_STEP    = 3'd2;
    localparam logic [2:0] ACT_FLOOR   = 3'd3;
    localparam logic [2:0] ACT_RESTART = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_START_X     = 3'd0;
    localparam logic [2:0] REG_START_Y     = 3'd1;
    localparam logic [2:0] REG_START_Z     = 3'd2;
    localparam logic [2:0] REG_INV_MASS    = 3'd3;
    localparam logic [2:0] REG_RADIUS      = 3'd4;
    localparam logic [2:0] REG_RESTITUTION = 3'd5;
    localparam logic [2:0] REG_FRICTION    = 3'd6;

    localparam logic signed [MUL_W-1:0] DAMP_LIN = 33'sd65470;
    localparam logic signed [MUL_W-1:0] DAMP_ANG = 33'sd64880;
    localparam logic [17:0]             FIX_ONE  = 18'h10000;

    typedef enum logic [2:0] {
        SEL_VEC,
        SEL_LACC,
        SEL_AACC,
        SEL_VEL,
        SEL_SPIN,
        SEL_NVEL
    } mul_sel_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_LACC_ADD,
        WB_AACC_ADD,
        WB_VEL_ADD,
        WB_SPIN_ADD,
        WB_POS_ADD,
        WB_VEL_SET,
        WB_SPIN_SET
    } wb_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     mul_en;
        wb_op_t   wb;
        logic     clr_acc;
        logic     clr_all;
    } lane_ctl_t;

    typedef struct packed {
        logic              hit;
        logic [FIX_W-1:0]  val;
    } sat_res_t;

    // drop 16 fraction bits (floor) and clip to 32-bit signed
    function automatic sat_res_t sat_prod(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-17:0] q;
        sat_res_t r;
        q = p[PROD_W-1:16];
        r.hit = !((&q[PROD_W-17:FIX_W-1]) || !(|q[PROD_W-17:FIX_W-1]));
        if (r.hit)
        begin
            r.val = q[PROD_W-17] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r.val = q[FIX_W-1:0];
        end
        return r;
    endfunction

    // clip a 33-bit signed sum to 32 bits
    function automatic sat_res_t sat_sum(input logic [FIX_W:0] s);
        sat_res_t r;
        r.hit = s[FIX_W] ^ s[FIX_W-1];
        if (r.hit)
        begin
            r.val = s[FIX_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r.val = s[FIX_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sbei_lane.sv @@
// one axis of the body: position, velocity, spin and both accumulators,
// with a shared multiplier and saturating writeback; uses sbei_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbei_lane (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sbei_pkg::lane_ctl_t      ctl,
    input  wire logic [31:0]              vec,
    input  wire logic signed [32:0]       mul_b,
    input  wire logic                     pos_ld,
    input  wire logic [31:0]              pos_val,
    output logic [31:0]                   pos,
    output logic [31:0]                   vel,
    output logic [31:0]                   spin,
    output logic                          sat_hit
);

    logic [31:0] pos_reg, pos_next;
    logic [31:0] vel_reg, vel_next;
    logic [31:0] spin_reg, spin_next;
    logic [31:0] lacc_reg, lacc_next;
    logic [31:0] aacc_reg, aacc_next;
    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_next;
    logic signed [32:0] mul_a;
    logic [31:0]        base;
    logic [32:0]        sum;
    sbei_pkg::sat_res_t fp;
    sbei_pkg::sat_res_t rs;

    always_comb
    begin
        case (ctl.mul_sel)
            sbei_pkg::SEL_VEC:  mul_a = {vec[31], vec};
            sbei_pkg::SEL_LACC: mul_a = {lacc_reg[31], lacc_reg};
            sbei_pkg::SEL_AACC: mul_a = {aacc_reg[31], aacc_reg};
            sbei_pkg::SEL_VEL:  mul_a = {vel_reg[31], vel_reg};
            sbei_pkg::SEL_SPIN: mul_a = {spin_reg[31], spin_reg};
            sbei_pkg::SEL_NVEL: mul_a = 33'sd0 - $signed({vel_reg[31], vel_reg});
            default:            mul_a = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        case (ctl.wb)
            sbei_pkg::WB_LACC_ADD: base = lacc_reg;
            sbei_pkg::WB_AACC_ADD: base = aacc_reg;
            sbei_pkg::WB_VEL_ADD:  base = vel_reg;
            sbei_pkg::WB_SPIN_ADD: base = spin_reg;
            sbei_pkg::WB_POS_ADD:  base = pos_reg;
            default:               base = '0;
        endcase
    end

    assign fp  = sbei_pkg::sat_prod(prod_reg);
    assign sum = {base[31], base} + {fp.val[31], fp.val};
    assign rs  = sbei_pkg::sat_sum(sum);

    always_comb
    begin
        pos_next  = pos_reg;
        vel_next  = vel_reg;
        spin_next = spin_reg;
        lacc_next = lacc_reg;
        aacc_next = aacc_reg;
        sat_hit   = 1'b0;
        case (ctl.wb)
            sbei_pkg::WB_LACC_ADD:
            begin
                lacc_next = rs.val;
                sat_hit   = fp.hit | rs.hit;
            end
            sbei_pkg::WB_AACC_ADD:
            begin
                aacc_next = rs.val;
                sat_hit   = fp.hit | rs.hit;
            end
            sbei_pkg::WB_VEL_ADD:
            begin
                vel_next = rs.val;
                sat_hit  = fp.hit | rs.hit;
            end
            sbei_pkg::WB_SPIN_ADD:
            begin
                spin_next = rs.val;
                sat_hit   = fp.hit | rs.hit;
            end
            sbei_pkg::WB_POS_ADD:
            begin
                pos_next = rs.val;
                sat_hit  = fp.hit | rs.hit;
            end
            sbei_pkg::WB_VEL_SET:
            begin
                vel_next = fp.val;
                sat_hit  = fp.hit;
            end
            sbei_pkg::WB_SPIN_SET:
            begin
                spin_next = fp.val;
                sat_hit   = fp.hit;
            end
            default:
            begin
                sat_hit = 1'b0;
            end
        endcase
        if (ctl.clr_acc)
        begin
            lacc_next = '0;
            aacc_next = '0;
        end
        if (ctl.clr_all)
        begin
            vel_next  = '0;
            spin_next = '0;
            lacc_next = '0;
            aacc_next = '0;
        end
        if (pos_ld)
        begin
            pos_next = pos_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            vel_reg  <= '0;
            spin_reg <= '0;
            lacc_reg <= '0;
            aacc_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            vel_reg  <= vel_next;
            spin_reg <= spin_next;
            lacc_reg <= lacc_next;
            aacc_reg <= aacc_next;
        end
    end

    assign pos  = pos_reg;
    assign vel  = vel_reg;
    assign spin = spin_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sbei_merge.sv @@
// merges the three lanes into one result beat: saturation flag collection
// and the output register with its handshake; uses sbei_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbei_merge (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  clr,
    input  wire logic                                  hit_en,
    input  wire logic                                  hit,
    input  wire logic                                  load,
    input  wire logic                                  grounded,
    input  wire logic [sbei_pkg::NUM_LANES-1:0][31:0]  pos,
    input  wire logic [sbei_pkg::NUM_LANES-1:0][31:0]  vel,
    input  wire logic [sbei_pkg::NUM_LANES-1:0][31:0]  spin,
    input  wire logic                                  ready,
    output logic                                       can_load,
    output logic                                       valid,
    output logic [295:0]                               data
);

    logic         sat_reg, sat_next;
    logic         valid_reg, valid_next;
    logic [295:0] data_reg;

    always_comb
    begin
        sat_next = sat_reg;
        if (clr)
        begin
            sat_next = 1'b0;
        end
        else if (hit_en && hit)
        begin
            sat_next = 1'b1;
        end
    end

    assign can_load = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sat_reg   <= sat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {6'b0, sat_reg, grounded, spin, vel, pos};
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sphere_body_euler_integrator_top.sv @@
// Sphere body explicit Euler integrator in signed Q16.16. Each input beat is one
// action (force, torque, step, floor check, restart) and gives exactly one result
// beat with the body state after it. Three axis lanes each hold one multiplier;
// every product is registered and written back, saturated, in the next cycle.
// Floor without contact, restart and unused codes need no product. An action is
// taken in ST_IDLE, runs its phases in ST_RUN and waits in ST_FIN until the
// output register is free; the result then may wait there while the next beat
// is taken. Configuration writes go through cfg_we/cfg_index/cfg_data while no
// action is in flight; the user must ensure this, the block does not enforce it.
// depends on sbei_pkg, sbei_lane, sbei_merge
`timescale 1ns / 1ps
`default_nettype none

module sphere_body_euler_integrator_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // vec_x, vec_y, vec_z, time_step, floor_height, one pad bit
    input  wire logic [159:0]  s_axis_tdata,
    // action
    input  wire logic [2:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, spin_x, spin_y, spin_z,
    // on_floor, saturated, six pad bits
    output logic [295:0]       m_axis_tdata
);

    localparam int LANE_Y = 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] phase_reg, phase_next;

    logic [31:0] start_x_reg, start_y_reg, start_z_reg;
    logic [30:0] inv_mass_reg, radius_reg;
    logic [16:0] restitution_reg, friction_reg;

    logic [2:0]                                 act_reg;
    logic [sbei_pkg::NUM_LANES-1:0][31:0]       vec_reg;
    logic [30:0]                                dt_reg;
    logic [31:0]                                floor_reg;

    logic grounded_reg, grounded_next;

    logic accept;
    logic last;
    logic out_can_load;
    logic out_load;
    logic floor_hit;
    logic contact;

    sbei_pkg::lane_ctl_t                        ctl  [sbei_pkg::NUM_LANES];
    logic signed [32:0]                         mul_b [sbei_pkg::NUM_LANES];
    logic [sbei_pkg::NUM_LANES-1:0]             pos_ld;
    logic [sbei_pkg::NUM_LANES-1:0][31:0]       pos_val;
    logic [sbei_pkg::NUM_LANES-1:0][31:0]       pos_all;
    logic [sbei_pkg::NUM_LANES-1:0][31:0]       vel_all;
    logic [sbei_pkg::NUM_LANES-1:0][31:0]       spin_all;
    logic [sbei_pkg::NUM_LANES-1:0]             lane_hit;

    logic signed [33:0] pen;
    logic signed [33:0] floor_ext;
    logic [32:0]        floor_sum;
    sbei_pkg::sat_res_t floor_res;
    logic [17:0]        keep;
    logic signed [32:0] keep_b;
    logic signed [32:0] dt_b;
    logic signed [32:0] inv_b;
    logic signed [32:0] rest_b;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            start_z_reg     <= '0;
            inv_mass_reg    <= 31'h0001_0000;
            radius_reg      <= 31'h0001_0000;
            restitution_reg <= 17'h08000;
            friction_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbei_pkg::REG_START_X:     start_x_reg     <= cfg_data;
                sbei_pkg::REG_START_Y:     start_y_reg     <= cfg_data;
                sbei_pkg::REG_START_Z:     start_z_reg     <= cfg_data;
                sbei_pkg::REG_INV_MASS:    inv_mass_reg    <= cfg_data[30:0];
                sbei_pkg::REG_RADIUS:      radius_reg      <= cfg_data[30:0];
                sbei_pkg::REG_RESTITUTION: restitution_reg <= cfg_data[16:0];
                sbei_pkg::REG_FRICTION:    friction_reg    <= cfg_data[16:0];
                default:                   start_x_reg     <= start_x_reg;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= s_axis_tuser;
            vec_reg[0] <= s_axis_tdata[31:0];
            vec_reg[1] <= s_axis_tdata[63:32];
            vec_reg[2] <= s_axis_tdata[95:64];
            dt_reg     <= s_axis_tdata[126:96];
            floor_reg  <= s_axis_tdata[158:127];
        end
    end

    // floor contact: pos_y - radius <= floor, exact
    assign pen       = $signed({{2{pos_all[LANE_Y][31]}}, pos_all[LANE_Y]})
                     - $signed({3'b0, radius_reg});
    assign floor_ext = $signed({{2{floor_reg[31]}}, floor_reg});
    assign contact   = (pen <= floor_ext);
    assign floor_sum = {floor_reg[31], floor_reg} + {2'b0, radius_reg};
    assign floor_res = sbei_pkg::sat_sum(floor_sum);

    assign keep   = sbei_pkg::FIX_ONE - {1'b0, friction_reg};
    assign keep_b = $signed({{15{keep[17]}}, keep});
    assign dt_b   = $signed({2'b0, dt_reg});
    assign inv_b  = $signed({2'b0, inv_mass_reg});
    assign rest_b = $signed({16'b0, restitution_reg});

    // action sequencer: drives every lane per phase
    always_comb
    begin
        last          = 1'b0;
        floor_hit     = 1'b0;
        grounded_next = grounded_reg;
        pos_ld        = '0;
        pos_val[0]    = start_x_reg;
        pos_val[1]    = start_y_reg;
        pos_val[2]    = start_z_reg;
        for (int i = 0; i < sbei_pkg::NUM_LANES; i++)
        begin
            ctl[i].mul_sel = sbei_pkg::SEL_VEC;
            ctl[i].mul_en  = 1'b0;
            ctl[i].wb      = sbei_pkg::WB_NONE;
            ctl[i].clr_acc = 1'b0;
            ctl[i].clr_all = 1'b0;
            mul_b[i]       = inv_b;
        end
        if (state_reg == ST_RUN)
        begin
            case (act_reg)
                sbei_pkg::ACT_FORCE, sbei_pkg::ACT_TORQUE:
                begin
                    for (int i = 0; i < sbei_pkg::NUM_LANES; i++)
                    begin
                        if (phase_reg == 3'd0)
                        begin
                            ctl[i].mul_en = 1'b1;
                        end
                        else
                        begin
                            ctl[i].wb = (act_reg == sbei_pkg::ACT_FORCE) ?
                                        sbei_pkg::WB_LACC_ADD : sbei_pkg::WB_AACC_ADD;
                        end
                    end
                    last = (phase_reg != 3'd0);
                end
                sbei_pkg::ACT_STEP:
                begin
                    for (int i = 0; i < sbei_pkg::NUM_LANES; i++)
                    begin
                        mul_b[i] = dt_b;
                        case (phase_reg)
                            3'd0:
                            begin
                                ctl[i].mul_sel = sbei_pkg::SEL_LACC;
                                ctl[i].mul_en  = 1'b1;
                            end
                            3'd1:
                            begin
                                ctl[i].wb      = sbei_pkg::WB_VEL_ADD;
                                ctl[i].mul_sel = sbei_pkg::SEL_AACC;
                                ctl[i].mul_en  = 1'b1;
                            end
                            3'd2:
                            begin
                                // position uses the freshly written velocity
                                ctl[i].wb      = sbei_pkg::WB_SPIN_ADD;
                                ctl[i].mul_sel = sbei_pkg::SEL_VEL;
                                ctl[i].mul_en  = 1'b1;
                            end
                            3'd3:
                            begin
                                ctl[i].wb      = sbei_pkg::WB_POS_ADD;
                                ctl[i].mul_sel = sbei_pkg::SEL_VEL;
                                ctl[i].mul_en  = 1'b1;
                                mul_b[i]       = sbei_pkg::DAMP_LIN;
                            end
                            3'd4:
                            begin
                                ctl[i].wb      = sbei_pkg::WB_VEL_SET;
                                ctl[i].mul_sel = sbei_pkg::SEL_SPIN;
                                ctl[i].mul_en  = 1'b1;
                                mul_b[i]       = sbei_pkg::DAMP_ANG;
                            end
                            default:
                            begin
                                ctl[i].wb      = sbei_pkg::WB_SPIN_SET;
                                ctl[i].clr_acc = 1'b1;
                            end
                        endcase
                    end
                    last = (phase_reg == 3'd5);
                end
                sbei_pkg::ACT_FLOOR:
                begin
                    if (phase_reg == 3'd0)
                    begin
                        if (contact)
                        begin
                            for (int i = 0; i < sbei_pkg::NUM_LANES; i++)
                            begin
                                ctl[i].mul_sel = sbei_pkg::SEL_VEL;
                                ctl[i].mul_en  = 1'b1;
                                mul_b[i]       = keep_b;
                            end
                            ctl[LANE_Y].mul_sel = sbei_pkg::SEL_NVEL;
                            mul_b[LANE_Y]       = rest_b;
                            pos_ld[LANE_Y]      = 1'b1;
                            pos_val[LANE_Y]     = floor_res.val;
                            floor_hit           = floor_res.hit;
                            grounded_next       = 1'b1;
                        end
                        else
                        begin
                            grounded_next = 1'b0;
                            last          = 1'b1;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < sbei_pkg::NUM_LANES; i++)
                        begin
                            ctl[i].wb = sbei_pkg::WB_VEL_SET;
                        end
                        last = 1'b1;
                    end
                end
                sbei_pkg::ACT_RESTART:
                begin
                    for (int i = 0; i < sbei_pkg::NUM_LANES; i++)
                    begin
                        ctl[i].clr_all = 1'b1;
                    end
                    pos_ld        = '1;
                    grounded_next = 1'b0;
                    last          = 1'b1;
                end
                default:
                begin
                    last = 1'b1;
                end
            endcase
        end
    end

    assign out_load = (state_reg == ST_FIN) && out_can_load;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                phase_next = '0;
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                phase_next = phase_reg + 3'd1;
                if (last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            grounded_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            grounded_reg <= grounded_next;
        end
    end

    for (genvar g = 0; g < sbei_pkg::NUM_LANES; g++)
    begin : g_lane
        sbei_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl[g]),
            .vec     (vec_reg[g]),
            .mul_b   (mul_b[g]),
            .pos_ld  (pos_ld[g]),
            .pos_val (pos_val[g]),
            .pos     (pos_all[g]),
            .vel     (vel_all[g]),
            .spin    (spin_all[g]),
            .sat_hit (lane_hit[g])
        );
    end

    sbei_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (accept),
        .hit_en   (state_reg == ST_RUN),
        .hit      ((|lane_hit) | floor_hit),
        .load     (out_load),
        .grounded (grounded_reg),
        .pos      (pos_all),
        .vel      (vel_all),
        .spin     (spin_all),
        .ready    (m_axis_tready),
        .can_load (out_can_load),
        .valid    (m_axis_tvalid),
        .data     (m_axis_tdata)
    );

    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("result beat raised outside the finish state");

    a_floor_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_axis_tdata[288] == $past(grounded_reg)))
        else $error("on_floor does not match the grounded state");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && act_reg == sbei_pkg::ACT_RESTART)
        |=> (m_axis_tdata[287:96] == '0 && m_axis_tdata[288] == 1'b0))
        else $error("restart left motion state behind");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN && phase_reg == 3'd0))
        else $error("accepted beat did not start the sequencer");

endmodule

`default_nettype wire

@@ tb/sphere_body_euler_integrator_top_test.sv @@
// testbench for sphere_body_euler_integrator_top: drives action beats, predicts the
// body state after each action in Q16.16 and checks every result beat field by field
// depends on sbei_pkg and the integrator RTL
`timescale 1ns / 1ps

module sphere_body_euler_integrator_top_test;

    localparam logic [2:0] ACT_SPARE5 = 3'd5;
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam logic [31:0] FIX_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FIX_MIN = 32'h8000_0000;
    localparam logic [31:0] FIX_1   = 32'h0001_0000;

    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] spin;
        logic             on_floor;
        logic             saturated;
    } body_state_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [31:0]   cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [159:0]  s_axis_tdata = '0;
    logic [2:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [295:0]  m_axis_tdata;

    // predicted body and its registers
    longint body_pos [3];
    longint body_vel [3];
    longint body_lacc [3];
    longint body_spin [3];
    longint body_aacc [3];
    bit     body_grounded;
    longint start_pos [3];
    longint inv_mass;
    longint radius;
    longint restitution;
    longint friction;
    bit     clipped;

    body_state_t pending_states [$];
    body_state_t got_state;
    body_state_t want_state;

    int mismatches = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    sphere_body_euler_integrator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // q16.16 product, floor on the dropped bits
    function automatic longint qmul(longint a, longint b);
        return clip32((a * b) >>> 16);
    endfunction

    function automatic void rebuild_body();
        for (int i = 0; i < 3; i++)
        begin
            body_pos[i] = start_pos[i];
            body_vel[i] = 0;
            body_lacc[i] = 0;
            body_spin[i] = 0;
            body_aacc[i] = 0;
        end
        body_grounded = 1'b0;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            sbei_pkg::REG_START_X:     start_pos[0] = longint'($signed(data));
            sbei_pkg::REG_START_Y:     start_pos[1] = longint'($signed(data));
            sbei_pkg::REG_START_Z:     start_pos[2] = longint'($signed(data));
            sbei_pkg::REG_INV_MASS:    inv_mass = longint'(data[30:0]);
            sbei_pkg::REG_RADIUS:      radius = longint'(data[30:0]);
            sbei_pkg::REG_RESTITUTION: restitution = longint'(data[16:0]);
            sbei_pkg::REG_FRICTION:    friction = longint'(data[16:0]);
            default:                   ;
        endcase
    endfunction

    task automatic integrate_action(input logic [2:0] act, input logic [31:0] vx, vy, vz,
                                    input logic [30:0] dt, input logic [31:0] fh);
        longint      v [3];
        longint      step_dt;
        longint      fy;
        longint      keep;
        body_state_t r;
        v[0] = longint'($signed(vx));
        v[1] = longint'($signed(vy));
        v[2] = longint'($signed(vz));
        step_dt = longint'(dt);
        fy = longint'($signed(fh));
        clipped = 1'b0;
        case (act)
            sbei_pkg::ACT_FORCE:
                for (int i = 0; i < 3; i++)
                    body_lacc[i] = clip32(body_lacc[i] + qmul(v[i], inv_mass));
            sbei_pkg::ACT_TORQUE:
                for (int i = 0; i < 3; i++)
                    body_aacc[i] = clip32(body_aacc[i] + qmul(v[i], inv_mass));
            sbei_pkg::ACT_STEP:
                for (int i = 0; i < 3; i++)
                begin
                    // position uses the velocity updated in this same step
                    body_vel[i] = clip32(body_vel[i] + qmul(body_lacc[i], step_dt));
                    body_pos[i] = clip32(body_pos[i] + qmul(body_vel[i], step_dt));
                    body_lacc[i] = 0;
                    body_spin[i] = clip32(body_spin[i] + qmul(body_aacc[i], step_dt));
                    body_aacc[i] = 0;
                    body_vel[i] = qmul(body_vel[i], longint'(sbei_pkg::DAMP_LIN));
                    body_spin[i] = qmul(body_spin[i], longint'(sbei_pkg::DAMP_ANG));
                end
            sbei_pkg::ACT_FLOOR:
                if (body_pos[1] - radius <= fy)
                begin
                    keep = longint'(sbei_pkg::FIX_ONE) - friction;
                    body_pos[1] = clip32(fy + radius);
                    body_vel[1] = qmul(-body_vel[1], restitution);
                    body_vel[0] = qmul(body_vel[0], keep);
                    body_vel[2] = qmul(body_vel[2], keep);
                    body_grounded = 1'b1;
                end
                else
                begin
                    body_grounded = 1'b0;
                end
            sbei_pkg::ACT_RESTART:
                rebuild_body();
            default:
                ;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            r.pos[i] = body_pos[i][31:0];
            r.vel[i] = body_vel[i][31:0];
            r.spin[i] = body_spin[i][31:0];
        end
        r.on_floor = body_grounded;
        r.saturated = clipped;
        pending_states.push_back(r);
    endtask

    // called at a falling edge, returns at a falling edge with tvalid still high
    task automatic send_action(input logic [2:0] act, input logic [31:0] vx, vy, vz,
                               input logic [30:0] dt, input logic [31:0] fh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {1'b0, fh, dt, vz, vy, vx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        integrate_action(act, vx, vy, vz, dt, fh);
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (pending_states.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        apply_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_random_action();
        logic [2:0]  act;
        logic [31:0] vx, vy, vz, fh;
        logic [30:0] dt;
        longint      h;
        int          r;
        bit          wild;
        r = $urandom_range(99);
        if (r < 26)
            act = sbei_pkg::ACT_FORCE;
        else if (r < 40)
            act = sbei_pkg::ACT_TORQUE;
        else if (r < 64)
            act = sbei_pkg::ACT_STEP;
        else if (r < 86)
            act = sbei_pkg::ACT_FLOOR;
        else if (r < 93)
            act = sbei_pkg::ACT_RESTART;
        else if (r < 96)
            act = ACT_SPARE5;
        else if (r < 98)
            act = ACT_SPARE6;
        else
            act = ACT_SPARE7;
        wild = ($urandom_range(99) < 20);
        if (wild)
        begin
            vx = $urandom;
            vy = $urandom;
            vz = $urandom;
            dt = 31'($urandom);
            fh = $urandom;
        end
        else
        begin
            // about +-16.0 per component, steps up to a quarter second
            vx = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            vy = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            vz = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            dt = 31'($urandom_range(32'h0000_4000));
            // floor placed near the sphere bottom so contact goes both ways
            h = body_pos[1] - radius + longint'($urandom_range(32'h0002_0000)) - 65536;
            fh = h[31:0];
        end
        send_action(act, vx, vy, vz, dt, fh);
    endtask

    task automatic run_random_phase(input int n, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        send_action(sbei_pkg::ACT_RESTART, $urandom, $urandom, $urandom, 31'($urandom),
                    $urandom);
        repeat (n) send_random_action();
        wait_quiet();
    endtask

    task automatic randomize_regs();
        write_reg(sbei_pkg::REG_START_X, $urandom_range(32'h0010_0000) - 32'h0008_0000);
        write_reg(sbei_pkg::REG_START_Y, $urandom_range(32'h0010_0000) - 32'h0008_0000);
        write_reg(sbei_pkg::REG_START_Z, $urandom_range(32'h0010_0000) - 32'h0008_0000);
        write_reg(sbei_pkg::REG_INV_MASS, $urandom_range(32'h0004_0000));
        write_reg(sbei_pkg::REG_RADIUS, $urandom_range(32'h0002_0000));
        write_reg(sbei_pkg::REG_RESTITUTION, $urandom_range(32'h0001_0000));
        write_reg(sbei_pkg::REG_FRICTION, $urandom_range(32'h0001_0000));
    endtask

    // spare action codes and restart from the reset state, plus a write to no register
    task automatic test_idle_state();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_action(ACT_SPARE5, FIX_MAX, FIX_MIN, FIX_1, 31'h7FFF_FFFF, FIX_MIN);
        send_action(ACT_SPARE6, 32'h0, 32'h0, 32'h0, 31'h0, 32'h0);
        send_action(ACT_SPARE7, FIX_MIN, FIX_MAX, FIX_MAX, 31'h0001_0000, FIX_MAX);
        send_action(sbei_pkg::ACT_RESTART, FIX_1, FIX_1, FIX_1, 31'h0001_0000, FIX_1);
        wait_quiet();
    endtask

    // accumulators saturating, step with unit, huge and zero intervals, mass extremes
    task automatic test_accumulate();
        send_action(sbei_pkg::ACT_FORCE, FIX_MAX, FIX_MIN, FIX_1, 31'h0, 32'h0);
        send_action(sbei_pkg::ACT_FORCE, FIX_MAX, FIX_MIN, FIX_1, 31'h0, 32'h0);
        send_action(sbei_pkg::ACT_TORQUE, FIX_MIN, FIX_MAX, 32'hFFFF_0000, 31'h0, 32'h0);
        send_action(sbei_pkg::ACT_TORQUE, FIX_MIN, FIX_MAX, 32'hFFFF_0000, 31'h0, 32'h0);
        send_action(sbei_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 31'h0001_0000, 32'h0);
        send_action(sbei_pkg::ACT_FORCE, FIX_1, FIX_MAX, 32'hFFFF_FFFF, 31'h0, 32'h0);
        send_action(sbei_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 32'h0);
        wait_quiet();
        write_reg(sbei_pkg::REG_INV_MASS, 32'h0);
        send_action(sbei_pkg::ACT_FORCE, FIX_MAX, FIX_MAX, FIX_MIN, 31'h0, 32'h0);
        wait_quiet();
        write_reg(sbei_pkg::REG_INV_MASS, FIX_MAX);
        send_action(sbei_pkg::ACT_FORCE, FIX_1, 32'hFFFF_0000, 32'h0000_0001, 31'h0, 32'h0);
        send_action(sbei_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 31'h0, 32'h0);
        wait_quiet();
    endtask

    // miss, hit, hit with overflowing height, exact touch, friction and bounce above 1.0
    task automatic test_floor_contact();
        write_reg(sbei_pkg::REG_INV_MASS, FIX_1);
        write_reg(sbei_pkg::REG_START_X, FIX_MAX);
        write_reg(sbei_pkg::REG_START_Y, 32'h0005_0000);
        write_reg(sbei_pkg::REG_START_Z, FIX_MIN);
        write_reg(sbei_pkg::REG_RESTITUTION, 32'h0001_0000);
        write_reg(sbei_pkg::REG_FRICTION, 32'hFFFF_FFFF);
        send_action(sbei_pkg::ACT_RESTART, 32'h0, 32'h0, 32'h0, 31'h0, 32'h0);
        send_action(sbei_pkg::ACT_FORCE, 32'h0002_0000, 32'hFFF8_0000, 32'hFFFD_0000,
                    31'h0, 32'h0);
        send_action(sbei_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 31'h0001_0000, 32'h0);
        send_action(sbei_pkg::ACT_FLOOR, 32'h0, 32'h0, 32'h0, 31'h0, 32'hFFEC_0000);
        send_action(sbei_pkg::ACT_FLOOR, 32'h0, 32'h0, 32'h0, 31'h0, 32'h0);
        send_action(sbei_pkg::ACT_FLOOR, 32'h0, 32'h0, 32'h0, 31'h0, FIX_MAX);
        wait_quiet();
        write_reg(sbei_pkg::REG_RADIUS, 32'h0);
        write_reg(sbei_pkg::REG_START_Y, FIX_MIN);
        write_reg(sbei_pkg::REG_RESTITUTION, 32'hFFFF_FFFF);
        send_action(sbei_pkg::ACT_RESTART, 32'h0, 32'h0, 32'h0, 31'h0, 32'h0);
        send_action(sbei_pkg::ACT_FLOOR, 32'h0, 32'h0, 32'h0, 31'h0, FIX_MIN);
        wait_quiet();
        write_reg(sbei_pkg::REG_RADIUS, FIX_MAX);
        send_action(sbei_pkg::ACT_FLOOR, 32'h0, 32'h0, 32'h0, 31'h0, 32'h0);
        wait_quiet();
    endtask

    task automatic test_random_phases();
        write_reg(sbei_pkg::REG_START_X, 32'h0);
        write_reg(sbei_pkg::REG_START_Y, 32'h0003_0000);
        write_reg(sbei_pkg::REG_START_Z, 32'h0);
        write_reg(sbei_pkg::REG_INV_MASS, FIX_1);
        write_reg(sbei_pkg::REG_RADIUS, 32'h0000_8000);
        write_reg(sbei_pkg::REG_RESTITUTION, 32'h0000_8000);
        write_reg(sbei_pkg::REG_FRICTION, 32'h0000_1999);
        run_random_phase(100, 0, 0);
        write_reg(sbei_pkg::REG_INV_MASS, 32'h0000_4000);
        write_reg(sbei_pkg::REG_RADIUS, 32'h0);
        write_reg(sbei_pkg::REG_RESTITUTION, 32'h0001_0000);
        write_reg(sbei_pkg::REG_FRICTION, 32'h0001_0000);
        run_random_phase(100, 77, 0);
        randomize_regs();
        run_random_phase(100, 0, 77);
        write_reg(sbei_pkg::REG_START_X, FIX_MIN);
        write_reg(sbei_pkg::REG_START_Y, FIX_MAX);
        write_reg(sbei_pkg::REG_START_Z, FIX_MAX);
        write_reg(sbei_pkg::REG_INV_MASS, FIX_MAX);
        write_reg(sbei_pkg::REG_RADIUS, FIX_MAX);
        write_reg(sbei_pkg::REG_RESTITUTION, 32'h0001_FFFF);
        write_reg(sbei_pkg::REG_FRICTION, 32'h0001_FFFF);
        run_random_phase(45, 36, 36);
        randomize_regs();
        run_random_phase(55, 36, 36);
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = HOLD_CYCLES;
        repeat (40) send_random_action();
        wait_quiet();
    endtask

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s at %0t: expected %h, got %h", what, $realtime, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            for (int i = 0; i < 3; i++)
            begin
                got_state.pos[i] = m_axis_tdata[32*i +: 32];
                got_state.vel[i] = m_axis_tdata[96 + 32*i +: 32];
                got_state.spin[i] = m_axis_tdata[192 + 32*i +: 32];
            end
            got_state.on_floor = m_axis_tdata[288];
            got_state.saturated = m_axis_tdata[289];
            if (pending_states.size() == 0)
            begin
                note_mismatch("unexpected result beat, pos_x", 32'h0, got_state.pos[0]);
            end
            else
            begin
                want_state = pending_states.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (got_state.pos[i] !== want_state.pos[i])
                        note_mismatch($sformatf("pos[%0d]", i), want_state.pos[i],
                                      got_state.pos[i]);
                    if (got_state.vel[i] !== want_state.vel[i])
                        note_mismatch($sformatf("vel[%0d]", i), want_state.vel[i],
                                      got_state.vel[i]);
                    if (got_state.spin[i] !== want_state.spin[i])
                        note_mismatch($sformatf("spin[%0d]", i), want_state.spin[i],
                                      got_state.spin[i]);
                end
                if (got_state.on_floor !== want_state.on_floor)
                    note_mismatch("on_floor", 32'(want_state.on_floor),
                                  32'(got_state.on_floor));
                if (got_state.saturated !== want_state.saturated)
                    note_mismatch("saturated", 32'(want_state.saturated),
                                  32'(got_state.saturated));
            end
        end
    end

    // cycles with no beat on either side; too many in a row end the run as failed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        start_pos[0] = 0;
        start_pos[1] = 0;
        start_pos[2] = 0;
        inv_mass = 65536;
        radius = 65536;
        restitution = 32768;
        friction = 0;
        rebuild_body();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_idle_state();
        test_accumulate();
        test_floor_contact();
        test_random_phases();
        test_backpressure();
        wait_quiet();
        if (mismatches == 0 && pending_states.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sphere_body_euler_integrator_top.f @@
hw/rtl/sbei_pkg.sv
hw/rtl/sbei_lane.sv
hw/rtl/sbei_merge.sv
hw/rtl/sphere_body_euler_integrator_top.sv
tb/sphere_body_euler_integrator_top_test.sv
